// ===== hdl/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// Source text lexer package
// Token and scan mode codes, character codes, the token record and the
// character classification helpers shared by the lexer modules.
// ----------------------------------------------------------------------------
package stl_pkg;

  typedef enum logic [4:0] {
    K_SEMI       = 5'd0,
    K_EOF        = 5'd1,
    K_LBRACE     = 5'd2,
    K_RBRACE     = 5'd3,
    K_LPAREN     = 5'd4,
    K_RPAREN     = 5'd5,
    K_PLUSPLUS   = 5'd6,
    K_PLUSEQ     = 5'd7,
    K_PLUS       = 5'd8,
    K_ARROW      = 5'd9,
    K_MINUSMINUS = 5'd10,
    K_MINUSEQ    = 5'd11,
    K_MINUS      = 5'd12,
    K_IDENT      = 5'd13,
    K_FUNCTION   = 5'd14,
    K_RETURN     = 5'd15,
    K_INT        = 5'd16,
    K_FLOAT      = 5'd17,
    K_UNKNOWN    = 5'd18
  } token_kind_t;

  typedef enum logic [3:0] {
    M_IDLE,
    M_IDENT,
    M_INT,
    M_INT_DOT,
    M_FLOAT,
    M_PLUS,
    M_MINUS,
    M_SLASH,
    M_LINE_CMT,
    M_BLOCK_CMT,
    M_BLOCK_STAR
  } scan_mode_t;

  // One token as it leaves the block, fields already clipped to 16 bits.
  typedef struct packed {
    token_kind_t kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
  } tok_t;

  localparam int unsigned TOK_SLOTS = 3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_R  = 8'h72;

  function automatic logic is_word_start(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_dec_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39);
  endfunction

  // Letters of the keyword "function" by position.
  function automatic logic [7:0] kw_fn_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h66;
      3'd1:    r = 8'h75;
      3'd2:    r = 8'h6E;
      3'd3:    r = 8'h63;
      3'd4:    r = 8'h74;
      3'd5:    r = 8'h69;
      3'd6:    r = 8'h6F;
      default: r = 8'h6E;
    endcase
    return r;
  endfunction

  // Letters of the keyword "return" by position; past its end nothing matches.
  function automatic logic [7:0] kw_ret_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h72;
      3'd1:    r = 8'h65;
      3'd2:    r = 8'h74;
      3'd3:    r = 8'h75;
      3'd4:    r = 8'h72;
      3'd5:    r = 8'h6E;
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/stl_burst.sv =====
// ----------------------------------------------------------------------------
// Lexer result burst register
// Holds the up to three tokens that one character produces and hands them
// out one per transfer, flagging the last one of the group.
// ----------------------------------------------------------------------------
module stl_burst (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  stl_pkg::tok_t                 toks [stl_pkg::TOK_SLOTS],
  input  logic [1:0]                    num,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output stl_pkg::tok_t                 cur,
  output logic                          last
);
  import stl_pkg::*;

  tok_t       slots [TOK_SLOTS];
  logic [1:0] count;
  logic [1:0] idx;
  logic       take;

  assign out_valid = (count != 2'd0);
  assign cur       = slots[idx];
  assign last      = out_valid && (idx == count - 2'd1);
  assign take      = out_valid && out_ready;
  // A new group may come in when nothing waits or the final token leaves now.
  assign free      = !out_valid || (take && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      idx   <= 2'd0;
    end else if (load) begin
      count <= num;
      idx   <= 2'd0;
    end else if (take) begin
      if (last) begin
        count <= 2'd0;
        idx   <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= toks;
    end
  end

endmodule

// ===== hdl/source_text_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// Source text lexer
// Streaming tokenizer: one source byte per transfer in, tokens out.
// ----------------------------------------------------------------------------
// Path: the first token of a character passes the input register, then the
// burst register at the output.
// Throughput: one character per cycle while each character yields at most one
// token and the output side accepts it; a character that yields more tokens
// holds the input until the burst register has handed out all of them.
// Reset: synchronous, active high; scanner returns to idle, line and column 1.
// ----------------------------------------------------------------------------
module source_text_lexer_unit #(
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned COLUMN_BITS = 16,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 ch,
  output logic                       out_valid,
  input  logic                       out_ready,
  output stl_pkg::token_kind_t       token_kind,
  output logic [15:0]                start_line,
  output logic [15:0]                start_column,
  output logic [15:0]                token_length,
  output logic                       last_of_run
);
  import stl_pkg::*;

  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

  // Clips a counter value, zero-extended to 32 bits, to the 16-bit outputs.
  function automatic logic [15:0] clip16(input logic [31:0] v);
    return (|v[31:16]) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic tok_t mk_tok(input token_kind_t k, input logic [31:0] l,
                                  input logic [31:0] c, input logic [31:0] n);
    tok_t t;
    t.kind = k;
    t.line = clip16(l);
    t.col  = clip16(c);
    t.len  = clip16(n);
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Input register. The character waits here until the burst register below
  // can take every token it produces; the next character is taken in the same
  // cycle as the stored one is consumed, so a stall on the output side still
  // lets one more character in.
  // --------------------------------------------------------------------------
  logic [7:0] ch_q;
  logic       in_full;
  logic       burst_free;
  logic       consume;

  assign consume  = in_full && burst_free;
  assign in_ready = !in_full || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (consume) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_q <= ch;
    end
  end

  // --------------------------------------------------------------------------
  // Scanner state. The keyword check keeps two running match flags instead of
  // the identifier's leading bytes: each flag stays set while the letters seen
  // so far agree with "function" or "return" at the same positions.
  // --------------------------------------------------------------------------
  scan_mode_t             mode, mode_next;
  logic [LINE_BITS-1:0]   cur_line, cur_line_next;
  logic [COLUMN_BITS-1:0] cur_col, cur_col_next;
  logic [LINE_BITS-1:0]   tok_line, tok_line_next;
  logic [COLUMN_BITS-1:0] tok_col, tok_col_next;
  logic [LENGTH_BITS-1:0] tok_cnt, tok_cnt_next;
  logic                   fn_ok, fn_ok_next;
  logic                   ret_ok, ret_ok_next;

  // Tokens that close a pending token (a, and b only for digits, dot,
  // non-digit) and the token of the character lexed from idle.
  tok_t       pend_a, pend_b, idle_tok;
  logic       a_v, b_v, idle_v;
  logic       again, was_reset;
  logic [32:0] dot_sum;
  logic [COLUMN_BITS-1:0] dot_col;
  tok_t       toks [TOK_SLOTS];
  logic [1:0] num;

  assign dot_sum = 33'(tok_col) + 33'(tok_cnt);
  assign dot_col = (dot_sum > 33'(COL_MAX)) ? COL_MAX : dot_sum[COLUMN_BITS-1:0];

  always_comb begin
    mode_next     = mode;
    cur_line_next = cur_line;
    cur_col_next  = cur_col;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    tok_cnt_next  = tok_cnt;
    fn_ok_next    = fn_ok;
    ret_ok_next   = ret_ok;
    pend_a        = mk_tok(K_UNKNOWN, 32'(tok_line), 32'(tok_col), 32'(tok_cnt));
    pend_b        = mk_tok(K_UNKNOWN, 32'(tok_line), 32'(dot_col), 32'd1);
    idle_tok      = mk_tok(K_UNKNOWN, 32'(cur_line), 32'(cur_col), 32'd1);
    a_v           = 1'b0;
    b_v           = 1'b0;
    idle_v        = 1'b0;
    again         = 1'b0;
    was_reset     = 1'b0;

    // Continue or close the token in progress.
    case (mode)
      M_IDENT: begin
        if (is_word_start(ch_q) || is_dec_char(ch_q)) begin
          if (tok_cnt < LENGTH_BITS'(8)) begin
            fn_ok_next  = fn_ok && (ch_q == kw_fn_char(tok_cnt[2:0]));
            ret_ok_next = ret_ok && (ch_q == kw_ret_char(tok_cnt[2:0]));
          end
          tok_cnt_next = (tok_cnt == LEN_MAX) ? tok_cnt : tok_cnt + 1'b1;
        end else begin
          a_v = 1'b1;
          if (tok_cnt == LENGTH_BITS'(8) && fn_ok) begin
            pend_a.kind = K_FUNCTION;
          end else if (tok_cnt == LENGTH_BITS'(6) && ret_ok) begin
            pend_a.kind = K_RETURN;
          end else begin
            pend_a.kind = K_IDENT;
          end
          again = 1'b1;
        end
      end
      M_INT: begin
        if (is_dec_char(ch_q)) begin
          tok_cnt_next = (tok_cnt == LEN_MAX) ? tok_cnt : tok_cnt + 1'b1;
        end else if (ch_q == CH_DOT) begin
          mode_next = M_INT_DOT;
        end else begin
          a_v         = 1'b1;
          pend_a.kind = K_INT;
          again       = 1'b1;
        end
      end
      M_INT_DOT: begin
        if (is_dec_char(ch_q)) begin
          tok_cnt_next = (tok_cnt >= LEN_MAX - 1'b1) ? LEN_MAX : tok_cnt + 2'd2;
          mode_next    = M_FLOAT;
        end else begin
          // Integer, then the dangling dot as an unknown token of its own.
          a_v         = 1'b1;
          pend_a.kind = K_INT;
          b_v         = 1'b1;
          again       = 1'b1;
        end
      end
      M_FLOAT: begin
        if (is_dec_char(ch_q)) begin
          tok_cnt_next = (tok_cnt == LEN_MAX) ? tok_cnt : tok_cnt + 1'b1;
        end else begin
          a_v         = 1'b1;
          pend_a.kind = K_FLOAT;
          again       = 1'b1;
        end
      end
      M_PLUS: begin
        mode_next = M_IDLE;
        a_v       = 1'b1;
        pend_a    = mk_tok(K_PLUSPLUS, 32'(tok_line), 32'(tok_col), 32'd2);
        if (ch_q == CH_PLUS) begin
          pend_a.kind = K_PLUSPLUS;
        end else if (ch_q == CH_EQUAL) begin
          pend_a.kind = K_PLUSEQ;
        end else begin
          pend_a = mk_tok(K_PLUS, 32'(tok_line), 32'(tok_col), 32'd1);
          again  = 1'b1;
        end
      end
      M_MINUS: begin
        mode_next = M_IDLE;
        a_v       = 1'b1;
        pend_a    = mk_tok(K_ARROW, 32'(tok_line), 32'(tok_col), 32'd2);
        if (ch_q == CH_GT) begin
          pend_a.kind = K_ARROW;
        end else if (ch_q == CH_MINUS) begin
          pend_a.kind = K_MINUSMINUS;
        end else if (ch_q == CH_EQUAL) begin
          pend_a.kind = K_MINUSEQ;
        end else begin
          pend_a = mk_tok(K_MINUS, 32'(tok_line), 32'(tok_col), 32'd1);
          again  = 1'b1;
        end
      end
      M_SLASH: begin
        if (ch_q == CH_SLASH) begin
          mode_next = M_LINE_CMT;
        end else if (ch_q == CH_STAR) begin
          mode_next = M_BLOCK_CMT;
        end else begin
          // A lone slash is an unknown token of length one.
          a_v    = 1'b1;
          pend_a = mk_tok(K_UNKNOWN, 32'(tok_line), 32'(tok_col), 32'd1);
          again  = 1'b1;
        end
      end
      M_LINE_CMT: begin
        again = (ch_q == CH_LF) || (ch_q == CH_NUL);
      end
      M_BLOCK_CMT: begin
        if (ch_q == CH_STAR) begin
          mode_next = M_BLOCK_STAR;
        end else if (ch_q == CH_NUL) begin
          again = 1'b1;
        end
      end
      M_BLOCK_STAR: begin
        if (ch_q == CH_SLASH) begin
          mode_next = M_IDLE;
        end else if (ch_q == CH_NUL) begin
          again = 1'b1;
        end else if (ch_q != CH_STAR) begin
          mode_next = M_BLOCK_CMT;
        end
      end
      default: begin
        again = 1'b1;
      end
    endcase

    // Lex the character afresh from idle when the previous token is done.
    if (again) begin
      mode_next = M_IDLE;
      case (ch_q) inside
        CH_NUL: begin
          // End of text: emit eof and return everything to its reset state.
          idle_v        = 1'b1;
          idle_tok.kind = K_EOF;
          was_reset     = 1'b1;
          cur_line_next = LINE_BITS'(1);
          cur_col_next  = COLUMN_BITS'(1);
          tok_line_next = '0;
          tok_col_next  = '0;
          tok_cnt_next  = '0;
          fn_ok_next    = 1'b0;
          ret_ok_next   = 1'b0;
        end
        CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
        end
        CH_SEMI: begin
          idle_v        = 1'b1;
          idle_tok.kind = K_SEMI;
        end
        CH_LBRACE: begin
          idle_v        = 1'b1;
          idle_tok.kind = K_LBRACE;
        end
        CH_RBRACE: begin
          idle_v        = 1'b1;
          idle_tok.kind = K_RBRACE;
        end
        CH_LPAREN: begin
          idle_v        = 1'b1;
          idle_tok.kind = K_LPAREN;
        end
        CH_RPAREN: begin
          idle_v        = 1'b1;
          idle_tok.kind = K_RPAREN;
        end
        CH_PLUS, CH_MINUS, CH_SLASH: begin
          mode_next     = (ch_q == CH_PLUS)  ? M_PLUS :
                          (ch_q == CH_MINUS) ? M_MINUS : M_SLASH;
          tok_line_next = cur_line;
          tok_col_next  = cur_col;
          tok_cnt_next  = LENGTH_BITS'(1);
        end
        default: begin
          if (is_word_start(ch_q) || is_dec_char(ch_q)) begin
            mode_next     = is_word_start(ch_q) ? M_IDENT : M_INT;
            tok_line_next = cur_line;
            tok_col_next  = cur_col;
            tok_cnt_next  = LENGTH_BITS'(1);
            fn_ok_next    = (ch_q == CH_LOW_F);
            ret_ok_next   = (ch_q == CH_LOW_R);
          end else begin
            idle_v = 1'b1;
          end
        end
      endcase
    end

    // Position tracking for every character but the end-of-text byte.
    if (!was_reset) begin
      if (ch_q == CH_LF) begin
        cur_line_next = (cur_line == LINE_MAX) ? cur_line : cur_line + 1'b1;
        cur_col_next  = COLUMN_BITS'(1);
      end else begin
        cur_col_next = (cur_col == COL_MAX) ? cur_col : cur_col + 1'b1;
      end
    end
  end

  // Pack the produced tokens in order into the three result slots.
  always_comb begin
    toks[0] = idle_tok;
    toks[1] = idle_tok;
    toks[2] = idle_tok;
    if (a_v && b_v) begin
      toks[0] = pend_a;
      toks[1] = pend_b;
      num     = idle_v ? 2'd3 : 2'd2;
    end else if (a_v) begin
      toks[0] = pend_a;
      num     = idle_v ? 2'd2 : 2'd1;
    end else begin
      num = idle_v ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      cur_line <= LINE_BITS'(1);
      cur_col  <= COLUMN_BITS'(1);
      tok_line <= '0;
      tok_col  <= '0;
      tok_cnt  <= '0;
      fn_ok    <= 1'b0;
      ret_ok   <= 1'b0;
    end else if (consume) begin
      mode     <= mode_next;
      cur_line <= cur_line_next;
      cur_col  <= cur_col_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
      tok_cnt  <= tok_cnt_next;
      fn_ok    <= fn_ok_next;
      ret_ok   <= ret_ok_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output side: the burst register takes the whole group of tokens at once
  // and presents them one transfer at a time.
  // --------------------------------------------------------------------------
  tok_t cur_tok;

  stl_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .load      (consume),
    .toks      (toks),
    .num       (num),
    .free      (burst_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cur       (cur_tok),
    .last      (last_of_run)
  );

  assign token_kind   = cur_tok.kind;
  assign start_line   = cur_tok.line;
  assign start_column = cur_tok.col;
  assign token_length = cur_tok.len;

endmodule
